[rtl/core/assert_macros.svh]
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check sampled on the rising clock, off while reset is high.
`define PRIM_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Concurrent check sampled on the rising clock, active through reset too.
`define PRIM_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

[rtl/core/prim_pkg.sv]
`timescale 1ns / 1ps

package prim_pkg;

   // width of the tested number
   localparam int DATA_BITS = 63;
   localparam int NUM_BASES = 7;
   localparam int BASE_BITS = 31;
   localparam int CMP_W = (DATA_BITS > BASE_BITS) ? DATA_BITS : BASE_BITS;
   localparam int BASE_IDX_W = $clog2(NUM_BASES);
   localparam int SHIFT_W = $clog2(DATA_BITS);
   localparam int REQ_TDATA_W = ((DATA_BITS + 7) / 8) * 8;
   localparam int RSP_TDATA_W = 8;

   typedef logic [DATA_BITS-1:0] num_type;

   typedef struct packed {
      logic    start;
      num_type x;
      num_type y;
      num_type m;
   } mul_req_type;

   typedef struct packed {
      logic    done;
      num_type prod;
   } mul_rsp_type;

   // fixed witness bases, tried in this order
   function automatic logic [BASE_BITS-1:0] prim_base(input logic [BASE_IDX_W-1:0] idx);
      logic [BASE_BITS-1:0] b;
      case (idx)
         BASE_IDX_W'(0): b = BASE_BITS'(2);
         BASE_IDX_W'(1): b = BASE_BITS'(325);
         BASE_IDX_W'(2): b = BASE_BITS'(9375);
         BASE_IDX_W'(3): b = BASE_BITS'(28178);
         BASE_IDX_W'(4): b = BASE_BITS'(450775);
         BASE_IDX_W'(5): b = BASE_BITS'(9780504);
         BASE_IDX_W'(6): b = BASE_BITS'(1795265022);
         default:        b = '0;
      endcase
      return b;
   endfunction

endpackage

[rtl/core/prim_mulmod.sv]
`timescale 1ns / 1ps

// Shift-add modular multiplier: one multiplier bit per cycle, top bit first.
module prim_mulmod (
   input  logic                  clock,
   input  logic                  reset,
   input  prim_pkg::mul_req_type req,
   output prim_pkg::mul_rsp_type rsp
);
   import prim_pkg::*;

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [SHIFT_W-1:0]   cnt_ff, cnt_in;
   num_type              r_ff, r_in;
   num_type              x_ff, x_in;
   num_type              y_ff, y_in;
   num_type              m_ff, m_in;

   logic [DATA_BITS:0]   dbl;
   num_type              dbl_red;
   logic [DATA_BITS:0]   sum;
   num_type              step_r;

   // double, reduce, add the multiplicand if the bit is set, reduce again
   always_comb begin
      dbl     = {r_ff, 1'b0};
      dbl_red = (dbl >= {1'b0, m_ff}) ? DATA_BITS'(dbl - {1'b0, m_ff}) : DATA_BITS'(dbl);
      sum     = {1'b0, dbl_red} + (y_ff[DATA_BITS-1] ? {1'b0, x_ff} : '0);
      step_r  = (sum >= {1'b0, m_ff}) ? DATA_BITS'(sum - {1'b0, m_ff}) : DATA_BITS'(sum);
   end

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      r_in    = r_ff;
      x_in    = x_ff;
      y_in    = y_ff;
      m_in    = m_ff;
      if (busy_ff) begin
         r_in   = step_r;
         y_in   = {y_ff[DATA_BITS-2:0], 1'b0};
         cnt_in = cnt_ff - SHIFT_W'(1);
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end else if (req.start) begin
         busy_in = 1'b1;
         cnt_in  = SHIFT_W'(DATA_BITS - 1);
         r_in    = '0;
         x_in    = req.x;
         y_in    = req.y;
         m_in    = req.m;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      r_ff   <= r_in;
      x_ff   <= x_in;
      y_ff   <= y_in;
      m_ff   <= m_in;
   end

   assign rsp.done = done_ff;
   assign rsp.prod = r_ff;

endmodule

[rtl/core/primality_test_64bit.sv]
`timescale 1ns / 1ps

// Channel   Dir   Word layout (low bit up)                 Handshake
// req_      in    number[62:0], zero pad to 64              tvalid/tready
// rsp_      out   prime_flag[0], zero pad to 8              tvalid/tready
//
// Work: every multiply runs in the shared shift-add unit, and a base needs about (bits of d +
// ones of d + up to c-1 squarings) multiplies. Zero, one, two, three and even numbers are
// settled in the class state and go straight to the done state; odd ones first pass
// through the split state, which splits n-1 into d * 2^c.
// req_tready is high only while idle; a finished word waits in the output register, and
// the next number may be taken while it waits. Reset is synchronous, active high.
module primality_test_64bit (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [prim_pkg::REQ_TDATA_W-1:0] req_tdata,  // number
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [prim_pkg::RSP_TDATA_W-1:0] rsp_tdata   // prime_flag
);
   import prim_pkg::*;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_CLASS,
      ST_SPLIT,
      ST_BASE,
      ST_POW,
      ST_POW_MUL,
      ST_POW_SQR,
      ST_CHECK,
      ST_SQ_TEST,
      ST_SQR,
      ST_DONE
   } state_type;

   state_type              state_ff, state_in;
   num_type                n_ff, n_in;
   num_type                nm1_ff, nm1_in;
   num_type                d_ff, d_in;        // odd part of n-1
   num_type                e_ff, e_in;        // remaining exponent
   num_type                r_ff, r_in;        // running power / witness value
   num_type                b_ff, b_in;        // squared base
   logic [SHIFT_W-1:0]     c_ff, c_in;
   logic [SHIFT_W-1:0]     j_ff, j_in;
   logic [BASE_IDX_W-1:0]  idx_ff, idx_in;
   logic                   prime_ff, prime_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic                   rsp_prime_ff, rsp_prime_in;

   mul_req_type            mul_req;
   mul_rsp_type            mul_rsp;

   logic [CMP_W-1:0]       base_wide;
   logic [CMP_W-1:0]       n_wide;
   logic                   last_base;
   logic                   accept;

   assign base_wide = CMP_W'(prim_base(idx_ff));
   assign n_wide    = CMP_W'(n_ff);
   assign last_base = (idx_ff == BASE_IDX_W'(NUM_BASES - 1));
   assign accept    = req_tvalid && req_tready;

   prim_mulmod u_mulmod (
      .clock (clock),
      .reset (reset),
      .req   (mul_req),
      .rsp   (mul_rsp)
   );

   always_comb begin
      state_in     = state_ff;
      n_in         = n_ff;
      nm1_in       = nm1_ff;
      d_in         = d_ff;
      e_in         = e_ff;
      r_in         = r_ff;
      b_in         = b_ff;
      c_in         = c_ff;
      j_in         = j_ff;
      idx_in       = idx_ff;
      prime_in     = prime_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_prime_in = rsp_prime_ff;
      mul_req.start = 1'b0;
      mul_req.x     = b_ff;
      mul_req.y     = b_ff;
      mul_req.m     = n_ff;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               n_in     = req_tdata[DATA_BITS-1:0];
               state_in = ST_CLASS;
            end
         end
         ST_CLASS: begin
            // settle zero, one, two, three and even numbers at once
            nm1_in = n_ff - DATA_BITS'(1);
            d_in   = n_ff - DATA_BITS'(1);
            c_in   = '0;
            if (n_ff <= DATA_BITS'(1)) begin
               prime_in = 1'b0;
               state_in = ST_DONE;
            end else if (n_ff <= DATA_BITS'(3)) begin
               prime_in = 1'b1;
               state_in = ST_DONE;
            end else if (!n_ff[0]) begin
               prime_in = 1'b0;
               state_in = ST_DONE;
            end else begin
               state_in = ST_SPLIT;
            end
         end
         ST_SPLIT: begin
            // strip one factor of two per cycle
            if (d_ff[0]) begin
               idx_in   = '0;
               state_in = ST_BASE;
            end else begin
               d_in = d_ff >> 1;
               c_in = c_ff + SHIFT_W'(1);
            end
         end
         ST_BASE: begin
            if (n_wide <= base_wide) begin
               prime_in = 1'b1;
               state_in = ST_DONE;
            end else begin
               r_in     = DATA_BITS'(1);
               b_in     = DATA_BITS'(base_wide);
               e_in     = d_ff;
               state_in = ST_POW;
            end
         end
         ST_POW: begin
            if (e_ff == '0) begin
               state_in = ST_CHECK;
            end else if (e_ff[0]) begin
               mul_req.start = 1'b1;
               mul_req.x     = r_ff;
               state_in      = ST_POW_MUL;
            end else begin
               mul_req.start = 1'b1;
               state_in      = ST_POW_SQR;
            end
         end
         ST_POW_MUL: begin
            // take r*b, start b*b in the same cycle
            if (mul_rsp.done) begin
               r_in          = mul_rsp.prod;
               mul_req.start = 1'b1;
               state_in      = ST_POW_SQR;
            end
         end
         ST_POW_SQR: begin
            if (mul_rsp.done) begin
               b_in     = mul_rsp.prod;
               e_in     = e_ff >> 1;
               state_in = ST_POW;
            end
         end
         ST_CHECK: begin
            j_in = SHIFT_W'(1);
            if (r_ff == DATA_BITS'(1) || r_ff == nm1_ff) begin
               if (last_base) begin
                  prime_in = 1'b1;
                  state_in = ST_DONE;
               end else begin
                  idx_in   = idx_ff + BASE_IDX_W'(1);
                  state_in = ST_BASE;
               end
            end else begin
               state_in = ST_SQ_TEST;
            end
         end
         ST_SQ_TEST: begin
            if (r_ff == nm1_ff) begin
               if (last_base) begin
                  prime_in = 1'b1;
                  state_in = ST_DONE;
               end else begin
                  idx_in   = idx_ff + BASE_IDX_W'(1);
                  state_in = ST_BASE;
               end
            end else if (j_ff >= c_ff) begin
               // this base is a witness: composite
               prime_in = 1'b0;
               state_in = ST_DONE;
            end else begin
               mul_req.start = 1'b1;
               mul_req.x     = r_ff;
               mul_req.y     = r_ff;
               state_in      = ST_SQR;
            end
         end
         ST_SQR: begin
            if (mul_rsp.done) begin
               r_in     = mul_rsp.prod;
               j_in     = j_ff + SHIFT_W'(1);
               state_in = ST_SQ_TEST;
            end
         end
         ST_DONE: begin
            // hold until the output register is free
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_prime_in = prime_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         n_ff         <= n_in;
         nm1_ff       <= nm1_in;
         d_ff         <= d_in;
         e_ff         <= e_in;
         r_ff         <= r_in;
         b_ff         <= b_in;
         c_ff         <= c_in;
         j_ff         <= j_in;
         idx_ff       <= idx_in;
         prime_ff     <= prime_in;
         rsp_prime_ff <= rsp_prime_in;
      end
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_TDATA_W'(rsp_prime_ff);

endmodule

[rtl/core/prim_checker.sv]
`timescale 1ns / 1ps

`include "assert_macros.svh"

module prim_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             req_tvalid,
   input logic                             req_tready,
   input logic [prim_pkg::REQ_TDATA_W-1:0] req_tdata,
   input logic                             rsp_tvalid,
   input logic                             rsp_tready,
   input logic [prim_pkg::RSP_TDATA_W-1:0] rsp_tdata
);
   import prim_pkg::*;

   // a stalled result word keeps its value
   `PRIM_ASSERT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata), "result word changed while stalled")

   // pad bits of the result word stay zero
   `PRIM_ASSERT(a_rsp_pad, clock, reset, rsp_tvalid |-> rsp_tdata[RSP_TDATA_W-1:1] == '0, "result pad bits set")

   // the block goes busy right after it takes a number, and no new result shows yet
   `PRIM_ASSERT(a_busy_after_take, clock, reset, req_tvalid && req_tready |=> !req_tready && !$rose(rsp_tvalid), "block not busy after taking a number")

   // nothing is offered right after reset
   `PRIM_ASSERT_ALWAYS(a_reset_quiet, clock, reset |=> !rsp_tvalid && req_tready, "result or busy state after reset")

endmodule

bind primality_test_64bit prim_checker u_prim_checker (.*);

[tb/tb_primality_test_64bit.sv]
`timescale 1ns / 1ps

// Streams numbers into the primality tester and checks every verdict against a
// Miller-Rabin predictor built on exact 128-bit products. A short directed list
// (trivial values, pseudoprimes, base boundaries, the largest values) comes
// first, then random numbers weighted toward small sizes, since a large prime
// keeps the block busy far longer than a small one.
module tb_primality_test_64bit;

   localparam int NUM_W = prim_pkg::DATA_BITS;
   localparam int REQ_W = prim_pkg::REQ_TDATA_W;
   localparam int RSP_W = prim_pkg::RSP_TDATA_W;

   localparam int RANDOM_WORDS   = 75;
   localparam int START_HOLD     = 400;   // receiver holds off right after reset
   localparam int MID_HOLD       = 3000;  // second long hold-off mid-run
   localparam int MID_HOLD_AT    = 60;    // result count that triggers it
   localparam int MAX_REPORTS    = 10;
   localparam int DRAIN_CYCLES   = 200;
   localparam longint unsigned CYCLES_PER_NUMBER = 90000;

   // witness bases, first base in the low slot
   localparam logic [6:0][31:0] WITNESS = {
      32'd1795265022, 32'd9780504, 32'd450775, 32'd28178, 32'd9375, 32'd325, 32'd2
   };

   typedef logic [NUM_W-1:0] number_type;

   typedef struct packed {
      number_type number;
      logic       prime_flag;
   } verdict_type;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_tvalid = 1'b0;
   logic             req_tready;
   logic [REQ_W-1:0] req_tdata = '0;
   logic             rsp_tvalid;
   logic             rsp_tready = 1'b0;
   logic [RSP_W-1:0] rsp_tdata;

   number_type  number_q[$];    // numbers still to be offered
   verdict_type verdict_q[$];   // verdicts owed by the block, oldest first

   int unsigned     words_total;
   int unsigned     words_sent;
   int unsigned     primes_sent;
   int unsigned     results_seen;
   int unsigned     mismatch_count;
   int unsigned     tx_wait;
   int unsigned     rx_hold;
   bit              tx_burst;
   bit              rx_burst;
   longint unsigned cycle_count = 0;
   longint unsigned cycle_limit = 64'hFFFF_FFFF_FFFF_FFFF;

   primality_test_64bit i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),   // number[62:0], zero pad bit 63
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)    // prime_flag[0], zero pad [7:1]
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // ---------------------------------------------------------------------
   // Predictor
   // ---------------------------------------------------------------------

   // exact (a * b) mod m through a full 128-bit product
   function automatic logic [63:0] mul_reduce(input logic [63:0] a, input logic [63:0] b,
                                              input logic [63:0] m);
      logic [127:0] wide;
      wide = {64'd0, a} * {64'd0, b};
      wide = wide % {64'd0, m};
      return wide[63:0];
   endfunction

   // square-and-multiply, base already below m
   function automatic logic [63:0] pow_reduce(input logic [63:0] base, input logic [63:0] ex,
                                              input logic [63:0] m);
      logic [63:0] acc;
      acc = 64'd1 % m;
      while (ex != 0) begin
         if (ex[0]) begin
            acc = mul_reduce(acc, base, m);
         end
         base = mul_reduce(base, base, m);
         ex = ex >> 1;
      end
      return acc;
   endfunction

   function automatic logic prime_verdict(input number_type number);
      logic [63:0] n;
      logic [63:0] odd_part;
      logic [63:0] w;
      logic [63:0] a;
      int unsigned twos;
      int unsigned sq;
      n = {1'b0, number};
      if (n <= 1) return 1'b0;
      if (n <= 3) return 1'b1;
      if (!n[0]) return 1'b0;
      // split n-1 into odd_part * 2^twos
      odd_part = n - 1;
      twos = 0;
      while (!odd_part[0]) begin
         odd_part = odd_part >> 1;
         twos++;
      end
      for (int i = 0; i < 7; i++) begin
         w = {32'd0, WITNESS[i]};
         // a number not above the current base has survived every earlier one
         if (n <= w) return 1'b1;
         a = pow_reduce(w, odd_part, n);
         if (a != 1) begin
            sq = 1;
            while (a != n - 1) begin
               if (sq >= twos) return 1'b0;
               a = mul_reduce(a, a, n);
               sq++;
            end
         end
      end
      return 1'b1;
   endfunction

   // ---------------------------------------------------------------------
   // Stimulus, end of run
   // ---------------------------------------------------------------------

   // append a number to the pending list
   task automatic queue_number(input number_type v);
      number_q.insert(number_q.size(), v);
   endtask

   initial begin : stimulus
      number_type  v;
      int unsigned pick;
      int unsigned k;

      // Directed: trivial values first, so the opening receiver hold-off fills
      // the block with quick verdicts and backs up the input.
      queue_number(63'd0);
      queue_number(63'd1);
      queue_number(63'd2);
      queue_number(63'd3);
      queue_number(63'd4);
      queue_number(63'd6);
      queue_number(63'd5);
      queue_number(63'd9);
      queue_number(63'd25);
      queue_number(63'd341);          // Fermat pseudoprime to base 2
      queue_number(63'd561);          // Carmichael number
      queue_number(63'd2047);         // strong pseudoprime to base 2
      queue_number(63'd325);          // equal to the second base
      queue_number(63'd9375);
      queue_number(63'd28179);
      queue_number(63'd450775);
      queue_number(63'd9780503);
      queue_number(63'd1795265021);   // just below the last base
      queue_number(63'd3215031751);   // strong pseudoprime to 2, 3, 5, 7
      queue_number(63'd2147483647);   // 2^31 - 1
      queue_number(63'h4000_0000_0000_0001); // n-1 is a pure power of two
      queue_number(63'd2305843009213693951); // 2^61 - 1
      queue_number(63'h7FFF_FFFF_FFFF_FFFE); // largest even
      queue_number(63'h7FFF_FFFF_FFFF_FFFF); // all ones, composite
      queue_number(63'd9223372036854775783); // largest prime below 2^63

      // Random: mostly small numbers to keep the run short, a few full width.
      for (int i = 0; i < RANDOM_WORDS; i++) begin
         pick = $urandom_range(0, 99);
         if (pick < 55) begin
            v = number_type'($urandom_range(0, 65535));
            if ($urandom_range(0, 3) != 0) v[0] = 1'b1;
         end else if (pick < 70) begin
            v = number_type'($urandom());
            v[0] = 1'b1;
         end else if (pick < 80) begin
            // land next to a base
            k = $urandom_range(0, 6);
            v = number_type'(WITNESS[k]) + number_type'($urandom_range(0, 8));
            if (k != 0) v = v - 4;
         end else if (pick < 92) begin
            v = number_type'({$urandom(), $urandom()});
            v[0] = 1'b1;
         end else if (pick < 96) begin
            v = number_type'({$urandom(), $urandom()});
            v[0] = 1'b0;
         end else begin
            v = number_type'($urandom_range(0, 3));
         end
         queue_number(v);
      end

      words_total = number_q.size();
      cycle_limit = 3 * (longint'(words_total) * (CYCLES_PER_NUMBER + 16)
                    + START_HOLD + MID_HOLD) + 10000;

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // wait for every word to go in and every verdict to come back
      while (!(words_sent == words_total && verdict_q.size() == 0)) @(posedge clock);
      // let a stray extra word show up if there is one
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("tb: %0d numbers tested (%0d prime), %0d verdicts checked, %0d mismatches",
               words_sent, primes_sent, results_seen, mismatch_count);
      $display("tb: directed edge values, pseudoprimes, base boundaries, random sizes 1-63 bits");
      if (mismatch_count == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

   // ---------------------------------------------------------------------
   // Request driver: offer queued numbers with random gaps
   // ---------------------------------------------------------------------

   always @(posedge clock) begin : req_driver
      verdict_type owed;
      if (reset) begin
         req_tvalid <= 1'b0;
         tx_wait <= 0;
      end else begin
         // word taken: predict its verdict right away
         if (req_tvalid && req_tready) begin
            owed.number = req_tdata[NUM_W-1:0];
            owed.prime_flag = prime_verdict(owed.number);
            verdict_q.insert(verdict_q.size(), owed);
            words_sent <= words_sent + 1;
            if (owed.prime_flag) primes_sent <= primes_sent + 1;
         end

         if (req_tvalid && !req_tready) begin
            // hold the word until the block takes it
         end else if (tx_wait != 0) begin
            req_tvalid <= 1'b0;
            tx_wait <= tx_wait - 1;
         end else if (number_q.size() != 0) begin
            req_tdata <= REQ_W'(number_q.pop_front());
            req_tvalid <= 1'b1;
            // gap after this word; flip between bursty and idle stretches
            if ($urandom_range(0, 15) == 0) tx_burst = !tx_burst;
            tx_wait <= tx_burst ? 0 : $urandom_range(0, 7);
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // ---------------------------------------------------------------------
   // Response monitor: stall at random, compare with the oldest verdict
   // ---------------------------------------------------------------------

   task automatic report_mismatch(input string what, input number_type number,
                                  input logic [RSP_W-1:0] want, input logic [RSP_W-1:0] got);
      mismatch_count++;
      if (mismatch_count <= MAX_REPORTS) begin
         $display("tb: %s at result %0d, number %0d: expected %0h, got %0h",
                  what, results_seen, number, want, got);
      end
   endtask

   always @(posedge clock) begin : rsp_monitor
      verdict_type owed;
      int unsigned pause;
      if (reset) begin
         rsp_tready <= 1'b0;
         rx_hold <= START_HOLD;
      end else if (rsp_tvalid && rsp_tready) begin
         results_seen++;
         if (verdict_q.size() == 0) begin
            report_mismatch("word with no number pending", '0, '0, rsp_tdata);
         end else begin
            owed = verdict_q.pop_front();
            // pad bits must stay zero along with the verdict bit
            if (rsp_tdata !== RSP_W'(owed.prime_flag)) begin
               report_mismatch("wrong verdict", owed.number, RSP_W'(owed.prime_flag),
                               rsp_tdata);
            end
         end
         // draw the stall before the next word
         if (results_seen == MID_HOLD_AT) begin
            pause = MID_HOLD;
         end else begin
            if ($urandom_range(0, 15) == 0) rx_burst = !rx_burst;
            pause = rx_burst ? 0 : $urandom_range(0, 7);
         end
         rx_hold <= pause;
         rsp_tready <= (pause == 0);
      end else if (rx_hold != 0) begin
         rx_hold <= rx_hold - 1;
         rsp_tready <= (rx_hold == 1);
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // ---------------------------------------------------------------------
   // Watchdog
   // ---------------------------------------------------------------------

   always @(posedge clock) begin : watchdog
      cycle_count <= cycle_count + 1;
      if (cycle_count > cycle_limit) begin
         $display("tb: timeout after %0d cycles, %0d of %0d words sent, %0d verdicts owed",
                  cycle_count, words_sent, words_total, verdict_q.size());
         $display("tb: failure");
         $finish;
      end
   end

endmodule
